// ----- rtl/rwl_pkg.sv -----
// Shared types and codes for the reader-writer lock unit.
// Holds request function codes, status and wake codes, and default widths.
// No dependencies.
package rwl_pkg;

  localparam int REQUESTER_W = 16;
  localparam int FUNC_W = 3;
  localparam int STATUS_W = 2;
  localparam int WAKE_W = 2;

  localparam int DEF_READER_COUNT_BITS = 29;
  localparam int DEF_WAITER_COUNT_BITS = 16;
  localparam int DEF_OWNER_ID_BITS = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_TRY_READ = 3'd0,
    FN_TRY_WRITE = 3'd1,
    FN_UNLOCK = 3'd2,
    FN_READ_WAIT_BEGIN = 3'd3,
    FN_READ_WAIT_END = 3'd4,
    FN_WRITE_WAIT_BEGIN = 3'd5,
    FN_WRITE_WAIT_END = 3'd6
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DENIED = 2'd3;

  localparam logic [WAKE_W-1:0] WAKE_NONE = 2'd0;
  localparam logic [WAKE_W-1:0] WAKE_WRITER = 2'd1;
  localparam logic [WAKE_W-1:0] WAKE_READERS = 2'd2;

  typedef struct packed {
    logic valid;
    func_t func;
    logic [REQUESTER_W-1:0] requester;
  } req_t;

endpackage

// ----- rtl/rwl_in_stage.sv -----
// Input register of the reader-writer lock unit.
// Captures one request beat per cycle into a request struct. Uses rwl_pkg.
module rwl_in_stage
  import rwl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  logic [FUNC_W-1:0] func,
  input  logic [REQUESTER_W-1:0] requester,
  output req_t req
);

  logic valid_r;
  logic [FUNC_W-1:0] func_r;
  logic [REQUESTER_W-1:0] requester_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func;
      requester_r <= requester;
    end
  end

  always_comb begin
    req.valid = valid_r;
    req.func = func_t'(func_r);
    req.requester = requester_r;
  end

endmodule

// ----- rtl/rwl_core.sv -----
// Lock state, request evaluation and result register of the lock unit.
// Takes one registered request per cycle and updates state in one pass. Uses rwl_pkg.
module rwl_core
  import rwl_pkg::*;
#(
  parameter int READER_COUNT_BITS = DEF_READER_COUNT_BITS,
  parameter int WAITER_COUNT_BITS = DEF_WAITER_COUNT_BITS,
  parameter int OWNER_ID_BITS = DEF_OWNER_ID_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_data,
  input  req_t req,
  output logic out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [WAKE_W-1:0] out_wake,
  output logic [READER_COUNT_BITS-1:0] out_reader_count,
  output logic out_write_held
);

  localparam logic [READER_COUNT_BITS-1:0] READER_ONE = READER_COUNT_BITS'(1);
  localparam logic [WAITER_COUNT_BITS-1:0] WAITER_ONE = WAITER_COUNT_BITS'(1);

  logic prefer_readers_r;
  logic write_owned_r, write_owned_nxt;
  logic [READER_COUNT_BITS-1:0] readers_r, readers_nxt;
  logic rd_wait_flag_r, rd_wait_flag_nxt;
  logic wr_wait_flag_r, wr_wait_flag_nxt;
  logic [WAITER_COUNT_BITS-1:0] rd_waiters_r, rd_waiters_nxt;
  logic [WAITER_COUNT_BITS-1:0] wr_waiters_r, wr_waiters_nxt;
  logic [OWNER_ID_BITS-1:0] owner_r, owner_nxt;

  logic out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [WAKE_W-1:0] wake_r, wake_nxt;
  logic [READER_COUNT_BITS-1:0] count_r;
  logic held_r;

  logic read_blocked, write_blocked;
  logic [WAKE_W-1:0] wake_pick;
  logic [OWNER_ID_BITS-1:0] who;

  assign who = OWNER_ID_BITS'(req.requester);
  assign read_blocked = write_owned_r || (!prefer_readers_r && wr_wait_flag_r);
  assign write_blocked = write_owned_r || (readers_r != '0);

  always_comb begin
    wake_pick = WAKE_NONE;
    if (prefer_readers_r) begin
      if (rd_wait_flag_r) begin
        wake_pick = WAKE_READERS;
      end else if (wr_wait_flag_r) begin
        wake_pick = WAKE_WRITER;
      end
    end else begin
      if (wr_wait_flag_r) begin
        wake_pick = WAKE_WRITER;
      end else if (rd_wait_flag_r) begin
        wake_pick = WAKE_READERS;
      end
    end
  end

  always_comb begin
    write_owned_nxt = write_owned_r;
    readers_nxt = readers_r;
    rd_wait_flag_nxt = rd_wait_flag_r;
    wr_wait_flag_nxt = wr_wait_flag_r;
    rd_waiters_nxt = rd_waiters_r;
    wr_waiters_nxt = wr_waiters_r;
    owner_nxt = owner_r;
    status_nxt = ST_DENIED;
    wake_nxt = WAKE_NONE;
    case (req.func)
      FN_TRY_READ: begin
        if (read_blocked) begin
          status_nxt = ST_BUSY;
        end else if (readers_r == '1) begin
          status_nxt = ST_LIMIT;
        end else begin
          readers_nxt = readers_r + READER_ONE;
          status_nxt = ST_OK;
        end
      end
      FN_TRY_WRITE: begin
        if (write_blocked) begin
          status_nxt = ST_BUSY;
        end else begin
          write_owned_nxt = 1'b1;
          owner_nxt = who;
          status_nxt = ST_OK;
        end
      end
      FN_UNLOCK: begin
        if (write_owned_r) begin
          if (owner_r == who) begin
            write_owned_nxt = 1'b0;
            owner_nxt = '0;
            status_nxt = ST_OK;
            wake_nxt = wake_pick;
          end
        end else if (readers_r != '0) begin
          readers_nxt = readers_r - READER_ONE;
          status_nxt = ST_OK;
          if (readers_r == READER_ONE) begin
            wake_nxt = wake_pick;
          end
        end
      end
      FN_READ_WAIT_BEGIN: begin
        if (!read_blocked) begin
          status_nxt = ST_OK;
        end else begin
          rd_wait_flag_nxt = 1'b1;
          if (rd_waiters_r != '1) begin
            rd_waiters_nxt = rd_waiters_r + WAITER_ONE;
          end
          status_nxt = ST_BUSY;
        end
      end
      FN_READ_WAIT_END: begin
        if (rd_waiters_r != '0) begin
          rd_waiters_nxt = rd_waiters_r - WAITER_ONE;
          if (rd_waiters_r == WAITER_ONE) begin
            rd_wait_flag_nxt = 1'b0;
          end
          status_nxt = ST_OK;
        end
      end
      FN_WRITE_WAIT_BEGIN: begin
        if (!write_blocked) begin
          status_nxt = ST_OK;
        end else begin
          wr_wait_flag_nxt = 1'b1;
          if (wr_waiters_r != '1) begin
            wr_waiters_nxt = wr_waiters_r + WAITER_ONE;
          end
          status_nxt = ST_BUSY;
        end
      end
      FN_WRITE_WAIT_END: begin
        if (wr_waiters_r != '0) begin
          wr_waiters_nxt = wr_waiters_r - WAITER_ONE;
          if (wr_waiters_r == WAITER_ONE) begin
            wr_wait_flag_nxt = 1'b0;
          end
          status_nxt = ST_OK;
        end
      end
      default: begin
        status_nxt = ST_DENIED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefer_readers_r <= 1'b0;
      write_owned_r <= 1'b0;
      readers_r <= '0;
      rd_wait_flag_r <= 1'b0;
      wr_wait_flag_r <= 1'b0;
      rd_waiters_r <= '0;
      wr_waiters_r <= '0;
      owner_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        prefer_readers_r <= cfg_data;
      end
      out_valid_r <= req.valid;
      if (req.valid) begin
        write_owned_r <= write_owned_nxt;
        readers_r <= readers_nxt;
        rd_wait_flag_r <= rd_wait_flag_nxt;
        wr_wait_flag_r <= wr_wait_flag_nxt;
        rd_waiters_r <= rd_waiters_nxt;
        wr_waiters_r <= wr_waiters_nxt;
        owner_r <= owner_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      status_r <= status_nxt;
      wake_r <= wake_nxt;
      count_r <= readers_nxt;
      held_r <= write_owned_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_wake = wake_r;
  assign out_reader_count = count_r;
  assign out_write_held = held_r;

endmodule

// ----- rtl/reader_writer_lock_unit.sv -----
// Top level of the reader-writer lock unit.
// Instantiates rwl_in_stage and rwl_core. Uses rwl_pkg.
//
//   channel  direction  handshake               beat
//   in_      input      start high, busy low    in_func, in_requester
//   out_     output     out_valid strobe        out_status, out_wake,
//                                               out_reader_count, out_write_held
//   cfg_     input      cfg_valid and cfg_ready cfg_data (prefer_readers)
//
// One request is accepted every cycle; busy is never raised.
// A result appears after the input register and the result register around the
// single pass of lock evaluation, and is shown for exactly one cycle.
// Reset is synchronous and clears all lock state.
// The receiver cannot stall results, and configuration is always ready.
module reader_writer_lock_unit
  import rwl_pkg::*;
#(
  parameter int READER_COUNT_BITS = DEF_READER_COUNT_BITS,
  parameter int WAITER_COUNT_BITS = DEF_WAITER_COUNT_BITS,
  parameter int OWNER_ID_BITS = DEF_OWNER_ID_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [REQUESTER_W-1:0] in_requester,
  output logic out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [WAKE_W-1:0] out_wake,
  output logic [READER_COUNT_BITS-1:0] out_reader_count,
  output logic out_write_held,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  req_t req;
  logic accept;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  rwl_in_stage u_in_stage (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .func(in_func),
    .requester(in_requester),
    .req(req)
  );

  rwl_core #(
    .READER_COUNT_BITS(READER_COUNT_BITS),
    .WAITER_COUNT_BITS(WAITER_COUNT_BITS),
    .OWNER_ID_BITS(OWNER_ID_BITS)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .req(req),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_wake(out_wake),
    .out_reader_count(out_reader_count),
    .out_write_held(out_write_held)
  );

endmodule

// ----- rtl/rwl_checker.sv -----
// Port-level checker for the reader-writer lock unit, bound to the top level.
// Uses rwl_pkg for function, status and wake codes.
module rwl_checker
  import rwl_pkg::*;
#(
  parameter int READER_COUNT_BITS = DEF_READER_COUNT_BITS
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic [FUNC_W-1:0] in_func,
  input logic out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [WAKE_W-1:0] out_wake,
  input logic [READER_COUNT_BITS-1:0] out_reader_count,
  input logic out_write_held
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("Accepted request produced no result.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("Result without a matching request.");

  a_wake_on_unlock: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake != WAKE_NONE) |->
      (out_status == ST_OK && $past(in_func, 2) == FN_UNLOCK))
    else $error("Wake target given outside a successful unlock.");

  a_writer_excludes_readers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_held) |-> (out_reader_count == '0))
    else $error("Writer holds the lock while readers are counted.");

endmodule

bind reader_writer_lock_unit rwl_checker #(
  .READER_COUNT_BITS(READER_COUNT_BITS)
) u_rwl_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_func(in_func),
  .out_valid(out_valid),
  .out_status(out_status),
  .out_wake(out_wake),
  .out_reader_count(out_reader_count),
  .out_write_held(out_write_held)
);

// ----- tb/tb.sv -----
// Self-checking testbench for reader_writer_lock_unit.
// Drives lock requests, predicts each response with a behavioral lock model,
// and compares every result beat field by field. Depends on rwl_pkg and the RTL.
module tb;
  import rwl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RC_W = DEF_READER_COUNT_BITS;
  localparam int WC_W = DEF_WAITER_COUNT_BITS;
  localparam logic [RC_W-1:0] READERS_FULL = {RC_W{1'b1}};
  localparam logic [WC_W-1:0] WAITERS_FULL = {WC_W{1'b1}};
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int WAIT_REPS = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WAKE_W-1:0] wake;
    logic [RC_W-1:0] reader_count;
    logic write_held;
  } lock_outcome_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [FUNC_W-1:0] in_func;
  logic [REQUESTER_W-1:0] in_requester;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [WAKE_W-1:0] out_wake;
  logic [RC_W-1:0] out_reader_count;
  logic out_write_held;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  lock_outcome_t lock_outcomes[$];
  int unsigned err_count;
  bit gapless;

  logic lk_prefer_readers;
  logic lk_write_owned;
  logic [RC_W-1:0] lk_readers;
  logic lk_rd_waiting;
  logic lk_wr_waiting;
  logic [WC_W-1:0] lk_rd_blocked;
  logic [WC_W-1:0] lk_wr_blocked;
  logic [REQUESTER_W-1:0] lk_owner;

  reader_writer_lock_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_requester(in_requester),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_wake(out_wake),
    .out_reader_count(out_reader_count),
    .out_write_held(out_write_held),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [WAKE_W-1:0] wake_target();
    if (lk_prefer_readers) begin
      if (lk_rd_waiting) return WAKE_READERS;
      if (lk_wr_waiting) return WAKE_WRITER;
    end else begin
      if (lk_wr_waiting) return WAKE_WRITER;
      if (lk_rd_waiting) return WAKE_READERS;
    end
    return WAKE_NONE;
  endfunction

  function automatic void apply_lock_request(input logic [FUNC_W-1:0] fn,
                                             input logic [REQUESTER_W-1:0] who);
    lock_outcome_t o;
    logic rd_blk;
    logic wr_blk;
    rd_blk = lk_write_owned || (!lk_prefer_readers && lk_wr_waiting);
    wr_blk = lk_write_owned || (lk_readers != '0);
    o.status = ST_DENIED;
    o.wake = WAKE_NONE;
    case (fn)
      FN_TRY_READ: begin
        if (rd_blk) o.status = ST_BUSY;
        else if (lk_readers == READERS_FULL) o.status = ST_LIMIT;
        else begin
          lk_readers = lk_readers + RC_W'(1);
          o.status = ST_OK;
        end
      end
      FN_TRY_WRITE: begin
        if (wr_blk) o.status = ST_BUSY;
        else begin
          lk_write_owned = 1'b1;
          lk_owner = who;
          o.status = ST_OK;
        end
      end
      FN_UNLOCK: begin
        if (lk_write_owned) begin
          if (lk_owner == who) begin
            lk_write_owned = 1'b0;
            lk_owner = '0;
            o.status = ST_OK;
            o.wake = wake_target();
          end
        end else if (lk_readers != '0) begin
          lk_readers = lk_readers - RC_W'(1);
          o.status = ST_OK;
          if (lk_readers == '0) o.wake = wake_target();
        end
      end
      FN_READ_WAIT_BEGIN: begin
        if (!rd_blk) o.status = ST_OK;
        else begin
          lk_rd_waiting = 1'b1;
          if (lk_rd_blocked != WAITERS_FULL) lk_rd_blocked = lk_rd_blocked + WC_W'(1);
          o.status = ST_BUSY;
        end
      end
      FN_READ_WAIT_END: begin
        if (lk_rd_blocked != '0) begin
          lk_rd_blocked = lk_rd_blocked - WC_W'(1);
          if (lk_rd_blocked == '0) lk_rd_waiting = 1'b0;
          o.status = ST_OK;
        end
      end
      FN_WRITE_WAIT_BEGIN: begin
        if (!wr_blk) o.status = ST_OK;
        else begin
          lk_wr_waiting = 1'b1;
          if (lk_wr_blocked != WAITERS_FULL) lk_wr_blocked = lk_wr_blocked + WC_W'(1);
          o.status = ST_BUSY;
        end
      end
      FN_WRITE_WAIT_END: begin
        if (lk_wr_blocked != '0) begin
          lk_wr_blocked = lk_wr_blocked - WC_W'(1);
          if (lk_wr_blocked == '0) lk_wr_waiting = 1'b0;
          o.status = ST_OK;
        end
      end
      default: o.status = ST_DENIED;
    endcase
    o.reader_count = lk_readers;
    o.write_held = lk_write_owned;
    lock_outcomes.push_back(o);
  endfunction

  // Most gaps are short; a few are long enough to span several result beats.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gapless || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    lock_outcome_t want;
    if (rst_n && out_valid) begin
      if (lock_outcomes.size() == 0) begin
        $error("result beat arrived with no request pending");
        err_count++;
      end else begin
        want = lock_outcomes.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          err_count++;
        end
        if (out_wake !== want.wake) begin
          $error("wake: expected %0d, actual %0d", want.wake, out_wake);
          err_count++;
        end
        if (out_reader_count !== want.reader_count) begin
          $error("reader_count: expected %0d, actual %0d", want.reader_count,
                 out_reader_count);
          err_count++;
        end
        if (out_write_held !== want.write_held) begin
          $error("write_held: expected %0d, actual %0d", want.write_held,
                 out_write_held);
          err_count++;
        end
      end
    end
  end

  task automatic send_request(input logic [FUNC_W-1:0] fn,
                              input logic [REQUESTER_W-1:0] who);
    int unsigned gap;
    start <= 1'b1;
    in_func <= fn;
    in_requester <= who;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_lock_request(fn, who);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    int unsigned spins;
    start <= 1'b0;
    spins = 0;
    while (lock_outcomes.size() != 0 && spins < 100) begin
      @(posedge clk);
      spins++;
    end
    if (lock_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", lock_outcomes.size());
      err_count++;
      lock_outcomes.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_prefer_readers(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lk_prefer_readers = value;
  endtask

  task automatic test_basic_locking();
    set_prefer_readers(1'b0);
    send_request(FN_TRY_READ, 16'h0000);
    send_request(FN_TRY_READ, 16'hFFFF);
    send_request(FN_TRY_WRITE, 16'h5A5A);
    send_request(FN_WRITE_WAIT_BEGIN, 16'h5A5A);
    send_request(FN_TRY_READ, 16'h1111);
    send_request(FN_UNLOCK, 16'h0000);
    send_request(FN_UNLOCK, 16'hFFFF);
    send_request(FN_UNLOCK, 16'h2222);
    send_request(FN_WRITE_WAIT_END, 16'h5A5A);
    send_request(FN_WRITE_WAIT_END, 16'h5A5A);
    send_request(FN_TRY_WRITE, 16'hFFFF);
    send_request(FN_TRY_WRITE, 16'h0001);
    send_request(FN_TRY_READ, 16'h0002);
    send_request(FN_READ_WAIT_BEGIN, 16'h0002);
    send_request(FN_UNLOCK, 16'h7FFF);
    send_request(FN_UNLOCK, 16'hFFFF);
    send_request(FN_READ_WAIT_BEGIN, 16'h0003);
    send_request(FN_READ_WAIT_END, 16'h0002);
    send_request(FN_READ_WAIT_END, 16'h0002);
    send_request(FN_UNUSED, 16'hA5A5);
    send_request(FN_WRITE_WAIT_BEGIN, 16'h0004);
    wait_idle();
  endtask

  task automatic test_reader_preference();
    set_prefer_readers(1'b1);
    send_request(FN_TRY_WRITE, 16'h0000);
    send_request(FN_READ_WAIT_BEGIN, 16'h0010);
    send_request(FN_WRITE_WAIT_BEGIN, 16'h0020);
    send_request(FN_UNLOCK, 16'h0000);
    send_request(FN_TRY_READ, 16'h0010);
    send_request(FN_TRY_READ, 16'h0011);
    send_request(FN_UNLOCK, 16'h0010);
    send_request(FN_READ_WAIT_END, 16'h0010);
    send_request(FN_UNLOCK, 16'h0011);
    send_request(FN_WRITE_WAIT_END, 16'h0020);
    send_request(FN_UNLOCK, 16'h0011);
    wait_idle();
  endtask

  // Stacks up both blocked-waiter counts back to back, then drains them one past empty.
  task automatic test_waiter_saturation();
    set_prefer_readers(1'b0);
    gapless = 1'b1;
    send_request(FN_TRY_WRITE, 16'h1234);
    repeat (WAIT_REPS) send_request(FN_READ_WAIT_BEGIN, 16'h0040);
    repeat (WAIT_REPS) send_request(FN_WRITE_WAIT_BEGIN, 16'h0041);
    send_request(FN_UNLOCK, 16'h1234);
    repeat (WAIT_REPS + 1) send_request(FN_READ_WAIT_END, 16'h0040);
    repeat (WAIT_REPS + 1) send_request(FN_WRITE_WAIT_END, 16'h0041);
    gapless = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [FUNC_W-1:0] fn;
    logic [REQUESTER_W-1:0] who;
    int unsigned r;
    for (int phase = 0; phase < 4; phase++) begin
      set_prefer_readers(phase[0] ? 1'b0 : 1'b1);
      for (int n = 0; n < 120; n++) begin
        gapless = (n % 100) < 25;
        r = $urandom_range(0, 99);
        who = REQUESTER_W'($urandom_range(0, 16'hFFFF));
        if (r < 18) fn = FN_TRY_READ;
        else if (r < 32) fn = FN_TRY_WRITE;
        else if (r < 56) begin
          fn = FN_UNLOCK;
          if (lk_write_owned) begin
            r = $urandom_range(0, 9);
            if (r < 7) who = lk_owner;
            else if (r < 9) who = lk_owner ^ (16'h1 << $urandom_range(0, 15));
          end
        end
        else if (r < 66) fn = FN_READ_WAIT_BEGIN;
        else if (r < 76) fn = FN_READ_WAIT_END;
        else if (r < 86) fn = FN_WRITE_WAIT_BEGIN;
        else if (r < 96) fn = FN_WRITE_WAIT_END;
        else fn = FN_UNUSED;
        send_request(fn, who);
        if ($urandom_range(0, 49) == 0) wait_idle();
      end
      gapless = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    err_count = 0;
    gapless = 1'b0;
    lk_prefer_readers = 1'b0;
    lk_write_owned = 1'b0;
    lk_readers = '0;
    lk_rd_waiting = 1'b0;
    lk_wr_waiting = 1'b0;
    lk_rd_blocked = '0;
    lk_wr_blocked = '0;
    lk_owner = '0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= FN_TRY_READ;
    in_requester <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_locking();
    test_reader_preference();
    test_waiter_saturation();
    test_random_traffic();
    set_prefer_readers(1'b0);
    wait_idle();
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rwl_pkg.sv
rtl/rwl_in_stage.sv
rtl/rwl_core.sv
rtl/reader_writer_lock_unit.sv
rtl/rwl_checker.sv
tb/tb.sv
